// ===== src/dofl_pkg.sv =====
package dofl_pkg;

	// Operation codes carried by the operation input.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_OFFSET_SHIFT = 2'd0;
	localparam logic [1:0] REG_ENTRY_COUNT  = 2'd1;
	localparam logic [1:0] REG_TABLE_VALID  = 2'd2;

	localparam int WORD_W  = 32;
	localparam int DISC_W  = 35;
	localparam int START_W = 34;
	localparam int END_W   = 35;
	localparam int LDIX_W  = 10;
	localparam int COUNT_W = 11;
	localparam int STEP_W  = 4;

	localparam logic [WORD_W-1:0] DIR_MASK = 32'hFF00_0000;

	typedef struct packed {
		logic              dir;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic vld;
	} scan_ctl_t;

endpackage

// ===== src/dofl_table.sv =====
module dofl_table import dofl_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	output logic             rd_vld
);

	entry_t mem [DEPTH];
	entry_t rd_data_s1;
	logic   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	assign rd_data = rd_data_s1;
	assign rd_vld  = rd_vld_s1;

endmodule

// ===== src/dofl_scan.sv =====
module dofl_scan import dofl_pkg::*; #(
	parameter int IDX_W = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  logic [1:0]         shift,
	input  entry_t             entry,
	input  logic [IDX_W-1:0]   entry_idx,
	input  logic [DISC_W-1:0]  query,
	output logic               have,
	output logic [START_W-1:0] best_start,
	output logic [IDX_W-1:0]   best_idx
);

	logic [START_W-1:0] start_c;
	logic [END_W-1:0]   end_c;
	logic               vld_s2;
	logic [START_W-1:0] start_s2;
	logic [END_W-1:0]   end_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               have_q;
	logic [END_W-1:0]   best_end_q;
	logic [START_W-1:0] best_start_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               take;

	always_comb begin
		start_c = START_W'(entry.offset) << shift;
		end_c   = END_W'(start_c) + END_W'(entry.size);
	end

	// Directories and empty files never take part in the search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld && !entry.dir && (entry.size != '0);
		end
	end

	always_ff @(posedge clk) begin
		start_s2 <= start_c;
		end_s2   <= end_c;
		idx_s2   <= entry_idx;
	end

	// Strictly less keeps the lowest index on a tie, as entries arrive in order.
	assign take = vld_s2 && (end_s2 > query) && (!have_q || (end_s2 < best_end_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && take) begin
			best_end_q   <= end_s2;
			best_start_q <= start_s2;
			best_idx_q   <= idx_s2;
		end
	end

	assign have       = have_q;
	assign best_start = best_start_q;
	assign best_idx   = best_idx_q;

`ifndef SYNTHESIS
	a_have_holds: assert property (@(posedge clk) disable iff (!arst_n)
		have_q && !ctl.clear |=> have_q)
		else $error("best candidate lost without a clear");

	a_end_above_start: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> best_end_q > END_W'(best_start_q))
		else $error("best candidate has an empty extent");

	a_end_above_query: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> best_end_q > query)
		else $error("best candidate ends at or below the query");
`endif

endmodule

// ===== src/disc_offset_to_file_lookup_unit.sv =====
// Disc offset to file lookup unit. Table entries are loaded one per command and a lookup
// command finds the file holding a disc byte offset. A command is taken when start is high
// while busy is low; a lookup answers with a single-cycle done strobe carrying found,
// match_index and match_start, and the receiver cannot hold that transfer off, so it must
// sample it in that cycle. A load gives no result; while busy it steps through the index
// reduction modulo MAX_ENTRIES (no steps when MAX_ENTRIES is 1024 or more) and then writes
// the entry. A lookup scans n entries, n being entry_count limited to MAX_ENTRIES: the
// single read port of the entry memory yields one entry per cycle, and the drain and done
// states then empty the compare pipeline and form the answer. A lookup with nothing to scan
// keeps busy high for a single cycle. done is high in the first cycle in which busy is low,
// and a new command may be taken in that same cycle. The user must write configuration over
// the APB port only while the unit is idle; the unit itself does not enforce this.
module disc_offset_to_file_lookup_unit import dofl_pkg::*; #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Command
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [LDIX_W-1:0]  entry_index,
	input  logic [WORD_W-1:0]  name_word,
	input  logic [WORD_W-1:0]  offset_word,
	input  logic [WORD_W-1:0]  size_word,
	input  logic [DISC_W-1:0]  query_offset,
	// Result
	output logic               done,
	output logic               found,
	output logic [LDIX_W-1:0]  match_index,
	output logic [START_W-1:0] match_start
);

	// Number of subtract steps that bring a load index below MAX_ENTRIES.
	function automatic int mod_steps(int depth);
		int n;
		n = 0;
		for (int k = 0; k < LDIX_W; k++) begin
			if ((depth << k) < (1 << LDIX_W)) begin
				n++;
			end
		end
		return n;
	endfunction

	localparam int IDX_W     = $clog2(MAX_ENTRIES);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int MOD_STEPS = mod_steps(MAX_ENTRIES);
	localparam int MOD_BASE  = (MAX_ENTRIES < (1 << LDIX_W)) ? MAX_ENTRIES : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MOD   = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic               accept;
	logic [1:0]         shift_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	logic               cfg_wr;
	logic [1:0]         eff_shift;
	logic [CNT_W-1:0]   n_c;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   i_q;
	logic               drain_q;
	logic [STEP_W-1:0]  step_q;
	logic [LDIX_W-1:0]  rem_q;
	logic [LDIX_W-1:0]  divisor;
	entry_t             ent_q;
	logic [DISC_W-1:0]  query_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   idx_s1;
	entry_t             rd_data;
	logic               rd_vld;
	logic               wr_en;
	scan_ctl_t          scan_ctl;
	logic               have;
	logic [START_W-1:0] best_start;
	logic [IDX_W-1:0]   best_idx;
	logic               done_q;
	logic               found_q;
	logic [LDIX_W-1:0]  match_index_q;
	logic [START_W-1:0] match_start_q;

	// Configuration registers. Every register reads back what was last written.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_OFFSET_SHIFT: shift_q <= pwdata[1:0];
				REG_ENTRY_COUNT:  count_q <= pwdata[COUNT_W-1:0];
				REG_TABLE_VALID:  valid_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OFFSET_SHIFT: prdata = {30'd0, shift_q};
			REG_ENTRY_COUNT:  prdata = {21'd0, count_q};
			REG_TABLE_VALID:  prdata = {31'd0, valid_q};
			default:          prdata = '0;
		endcase
	end

	// A shift code of three behaves as two.
	assign eff_shift = (shift_q == 2'd3) ? 2'd2 : shift_q;

	// The scan never runs past the end of the table.
	assign n_c = (32'(count_q) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(count_q);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The load index is reduced modulo MAX_ENTRIES by restoring subtraction,
	// largest multiple of the table depth first.
	assign divisor = LDIX_W'(MOD_BASE) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= 1'b0;
			i_q     <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_LOOKUP) begin
							i_q     <= '0;
							state_q <= (n_c == '0) ? ST_DONE : ST_SCAN;
						end else begin
							step_q  <= STEP_W'(MOD_STEPS - 1);
							state_q <= (MOD_STEPS > 0) ? ST_MOD : ST_WRITE;
						end
					end
				end
				ST_MOD: begin
					if (step_q == '0) begin
						state_q <= ST_WRITE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					i_q <= i_q + 1'b1;
					if (i_q == n_q - CNT_W'(1)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The drain carries the last entry through the table read register and the compare stage.
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command payload, captured when the command transfer is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q         <= n_c;
			rem_q       <= entry_index;
			ent_q.dir    <= (name_word & DIR_MASK) != '0;
			ent_q.offset <= offset_word;
			ent_q.size   <= size_word;
		end else if (state_q == ST_MOD && rem_q >= divisor) begin
			rem_q <= rem_q - divisor;
		end
		if (accept && operation == OP_LOOKUP) begin
			query_q <= query_offset;
		end
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	assign wr_en   = (state_q == ST_WRITE);
	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = i_q[IDX_W-1:0];

	dofl_table #(
		.DEPTH (MAX_ENTRIES),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(rem_q)),
		.wr_data (ent_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_vld  (rd_vld)
	);

	assign scan_ctl.clear = accept && (operation == OP_LOOKUP);
	assign scan_ctl.vld   = rd_vld;

	dofl_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.shift      (eff_shift),
		.entry      (rd_data),
		.entry_idx  (idx_s1),
		.query      (query_q),
		.have       (have),
		.best_start (best_start),
		.best_idx   (best_idx)
	);

	// Result transfer. The chosen file only counts when it starts at or below
	// the queried offset and the table has been marked valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			if (valid_q && have && (DISC_W'(best_start) <= query_q)) begin
				found_q       <= 1'b1;
				match_index_q <= LDIX_W'(best_idx);
				match_start_q <= best_start;
			end else begin
				found_q       <= 1'b0;
				match_index_q <= '0;
				match_start_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign match_index = match_index_q;
	assign match_start = match_start_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command taken without going busy");

	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while a command is still in work");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> i_q < n_q)
		else $error("scan read beyond the entries in use");
`endif

endmodule
